FILE: rtl/wpm_pkg.sv
// Shared types and constants for the wildcard pattern matcher.
package wpm_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_APPEND  = 2'd1,
        OP_RESTART = 2'd2,
        OP_TEXT    = 2'd3
    } t_op;

    localparam logic [7:0] STAR_BYTE = 8'h2A;
    localparam logic [7:0] ANY_BYTE  = 8'h3F;

    typedef struct packed {
        logic       step;
        logic       text;
        logic [7:0] sym;
    } t_cell_ctl;

    typedef struct packed {
        logic       matched;
        logic       overflow;
        logic [5:0] pattern_count;
    } t_result;

endpackage

FILE: rtl/wildcard_pattern_matcher.sv
// Top level of the wildcard pattern matcher: cell chain, length control, output buffer.
//
//   channel | valid   | stall   | payload
//   --------+---------+---------+-------------------------------------------
//   input   | i_valid | o_stall | i_operation, i_symbol
//   output  | o_valid | i_stall | o_matched, o_overflow, o_pattern_count
//
// One transaction per cycle while not stalled; results are registered in the buffer.
// Each text byte updates every cell in the same cycle through a one-bit ripple
// along the chain of MAX_PATTERN cells.
// Synchronous reset clears the length and the cell column bits and sets column bit 0;
// the pattern store keeps its contents and needs no clearing pass.
// A two-entry output buffer raises o_stall only when both entries are held.
module wildcard_pattern_matcher
    import wpm_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_symbol,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_matched,
    output logic       o_overflow,
    output logic [5:0] o_pattern_count
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    t_op              op;
    logic             in_fire;
    logic             append_ok;
    logic             overflow;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic             r_col0;
    t_cell_ctl        ctl;
    logic [MAX_PATTERN:0] col;
    logic [MAX_PATTERN:0] chain;
    t_result          result;
    t_result          out_data;

    assign op        = t_op'(i_operation);
    assign in_fire   = i_valid & ~o_stall;
    assign append_ok = (op == OP_APPEND) && (r_len < LEN_W'(MAX_PATTERN));
    assign overflow  = (op == OP_APPEND) && !append_ok;

    always_comb begin
        unique case (op)
            OP_CLEAR:   n_len = '0;
            OP_APPEND:  n_len = append_ok ? r_len + LEN_W'(1) : r_len;
            OP_RESTART: n_len = r_len;
            OP_TEXT:    n_len = r_len;
            default:    n_len = r_len;
        endcase
    end

    assign ctl.step = in_fire & ~overflow;
    assign ctl.text = (op == OP_TEXT);
    assign ctl.sym  = i_symbol;

    assign col[0]   = r_col0;
    assign chain[0] = ~ctl.text;

    for (genvar g = 1; g <= MAX_PATTERN; g++) begin : g_cell
        wpm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_wr         (in_fire & append_ok & (r_len == LEN_W'(g - 1))),
            .i_col_left   (col[g-1]),
            .i_chain_left (chain[g-1]),
            .o_col        (col[g]),
            .o_chain      (chain[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_col0 <= 1'b1;
        end else if (in_fire) begin
            r_len <= n_len;
            if (ctl.step) begin
                r_col0 <= chain[0];
            end
        end
    end

    assign result.matched       = overflow ? col[n_len] : chain[n_len];
    assign result.overflow      = overflow;
    assign result.pattern_count = 6'(n_len);

    wpm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_fire),
        .i_data  (result),
        .o_full  (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_data)
    );

    assign o_matched       = out_data.matched;
    assign o_overflow      = out_data.overflow;
    assign o_pattern_count = out_data.pattern_count;

endmodule

FILE: rtl/wpm_cell.sv
// One matcher cell: a stored pattern byte and its prefix match bit.
module wpm_cell
    import wpm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_wr,
    input  logic      i_col_left,
    input  logic      i_chain_left,
    output logic      o_col,
    output logic      o_chain
);

    logic [7:0] r_pat;
    logic       r_col;
    logic [7:0] pat_eff;
    logic       is_star;
    logic       is_hit;

    assign pat_eff = i_wr ? i_ctl.sym : r_pat;
    assign is_star = (pat_eff == STAR_BYTE);
    assign is_hit  = (pat_eff == ANY_BYTE) || (pat_eff == i_ctl.sym);

    always_comb begin
        if (!i_ctl.text) begin
            o_chain = i_chain_left & is_star;
        end else if (is_star) begin
            o_chain = r_col | i_chain_left;
        end else if (is_hit) begin
            o_chain = i_col_left;
        end else begin
            o_chain = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 1'b0;
        end else if (i_ctl.step) begin
            r_col <= o_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_pat <= i_ctl.sym;
        end
    end

    assign o_col = r_col;

endmodule

FILE: rtl/wpm_out_buf.sv
// Two-entry output buffer: result register plus skid register.
module wpm_out_buf
    import wpm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    out_free;

    assign out_free = ~r_out_valid | ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid  <= r_skid_valid | i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end
        if (!out_free && i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_full  = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: rtl/wpm_checker.sv
// Port-level assertions for the wildcard pattern matcher, bound to the top level.
module wpm_checker
    import wpm_pkg::*;
#(
    parameter int MAX_PATTERN = 32
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_operation,
    input logic [7:0] i_symbol,
    input logic       o_valid,
    input logic       i_stall,
    input logic       o_matched,
    input logic       o_overflow,
    input logic [5:0] o_pattern_count
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("buffer not empty after reset");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !o_valid) |=> o_valid)
        else $error("accepted transaction produced no result");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (o_pattern_count == 6'(MAX_PATTERN)))
        else $error("overflow flagged with store not full");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !o_valid && i_operation == OP_CLEAR)
        |=> (o_pattern_count == 6'd0) && o_matched && !o_overflow)
        else $error("clear did not empty the pattern");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid && $stable(o_matched) &&
        $stable(o_overflow) && $stable(o_pattern_count))
        else $error("stalled result changed");

endmodule

bind wildcard_pattern_matcher wpm_checker #(
    .MAX_PATTERN (MAX_PATTERN)
) u_wpm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_operation     (i_operation),
    .i_symbol        (i_symbol),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_matched       (o_matched),
    .o_overflow      (o_overflow),
    .o_pattern_count (o_pattern_count)
);
